// ----- src/preheat_wash_cycle_controller_assert.svh -----
// Assertion helpers for the preheat/wash controller.
`ifndef PREHEAT_WASH_CYCLE_CONTROLLER_ASSERT_SVH
`define PREHEAT_WASH_CYCLE_CONTROLLER_ASSERT_SVH

// Same-cycle implication.
`define PWCC_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PWCC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ----- src/pwcc_pkg.sv -----
package pwcc_pkg;

    localparam int unsigned MAX_WASH_MINUTES_DEF = 240;

    typedef enum logic [3:0] {
        OP_TICK         = 4'd0,
        OP_PREHEAT      = 4'd1,
        OP_WASH         = 4'd2,
        OP_PREHEAT_WASH = 4'd3,
        OP_HEAT_ON      = 4'd4,
        OP_HEAT_OFF     = 4'd5,
        OP_PUMP_OFF     = 4'd6,
        OP_PUMP_HALF    = 4'd7,
        OP_PUMP_FULL    = 4'd8
    } opcode_t;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'd0,
        PH_PREHEAT = 2'd1,
        PH_WASH    = 2'd2
    } phase_t;

    typedef enum logic [1:0] {
        PUMP_OFF  = 2'd0,
        PUMP_HALF = 2'd1,
        PUMP_FULL = 2'd2
    } pump_t;

    typedef enum logic [1:0] {
        EV_NONE       = 2'd0,
        EV_PREHEAT    = 2'd1,
        EV_WASH       = 2'd2,
        EV_CYCLE_DONE = 2'd3
    } event_t;

    typedef enum logic [1:0] {
        CFG_TARGET    = 2'd0,
        CFG_MINUTES   = 2'd1,
        CFG_FULL_DUTY = 2'd2
    } cfg_index_t;

    localparam logic [6:0]  TARGET_RESET    = 7'd40;
    localparam logic [7:0]  MINUTES_RESET   = 8'd10;
    localparam logic [7:0]  FULL_DUTY_RESET = 8'd255;
    localparam logic [7:0]  HALF_DUTY       = 8'd3;
    localparam logic [6:0]  TARGET_MIN      = 7'd20;
    localparam logic [6:0]  TARGET_MAX      = 7'd45;
    localparam logic [8:0]  CHECK_GAP_MS    = 9'd333;
    localparam logic [8:0]  SINCE_MAX       = 9'd511;
    localparam logic [9:0]  MS_LAST         = 10'd999;
    localparam logic [14:0] SEC_PER_MIN     = 15'd60;
    localparam logic [16:0] SEC_PER_STEP    = 17'd5;
    // 2^24-1 ms split into seconds and leftover milliseconds
    localparam logic [14:0] WASH_SEC_MAX    = 15'd16777;
    localparam logic [9:0]  WASH_MS_MAX     = 10'd215;

    // Wash time is kept as seconds plus milliseconds (0..999), so whole
    // seconds come straight out of the state.
    typedef struct packed {
        phase_t      phase;
        logic        chain;
        logic        heater_en;
        logic        heater_lvl;
        pump_t       pump;
        logic [8:0]  since_ms;
        logic [6:0]  target;
        logic [14:0] wash_sec;
        logic [9:0]  wash_ms;
    } state_t;

    typedef struct packed {
        logic [3:0]         op;
        logic signed [15:0] heater_temp;
        logic signed [15:0] pipe_temp;
        logic signed [4:0]  enc_delta;
        logic               long_click;
    } item_t;

    typedef struct packed {
        logic        heater_drive;
        logic [7:0]  pump_duty;
        logic [1:0]  phase;
        logic [14:0] remaining_seconds;
        logic [6:0]  working_target;
        logic [1:0]  end_event;
    } result_t;

endpackage

// ----- src/pwcc_step.sv -----
module pwcc_step
    import pwcc_pkg::*;
#(
    parameter int unsigned MAX_WASH_MINUTES = MAX_WASH_MINUTES_DEF
) (
    input  item_t      item,
    input  state_t     cur,
    input  logic [7:0] minutes,
    input  logic [7:0] full_duty,
    output state_t     nxt,
    output result_t    res
);

    logic signed [17:0] tgt_s;
    logic signed [17:0] h_hi;
    logic signed [17:0] h_lo;
    logic signed [17:0] p_s;
    logic               fire;
    logic               therm_lvl;
    logic [8:0]         therm_since;
    logic signed [8:0]  trim_s;
    logic [6:0]         trim;
    logic               pre_done;
    logic [8:0]         min_c;
    logic [14:0]        start_sec;
    logic [14:0]        dec_sec;
    logic [9:0]         dec_ms;
    logic signed [16:0] add_s;
    logic [14:0]        add_sec;
    logic [9:0]         add_ms;
    logic               wash_done;
    event_t             ev;

    // thermostat, evaluated on the current state
    assign tgt_s = $signed({4'b0, 14'(cur.target) * 14'd100});
    assign h_hi  = $signed({{2{item.heater_temp[15]}}, item.heater_temp}) + 18'sd200;
    assign h_lo  = $signed({{2{item.heater_temp[15]}}, item.heater_temp}) + 18'sd100;
    assign p_s   = $signed({{2{item.pipe_temp[15]}}, item.pipe_temp}) + 18'sd100;
    assign fire  = cur.heater_en && (cur.since_ms > CHECK_GAP_MS);

    always_comb begin
        if (!fire) begin
            therm_lvl = cur.heater_lvl;
        end else if (cur.heater_lvl) begin
            therm_lvl = !(h_hi >= tgt_s);
        end else begin
            therm_lvl = (h_lo <= tgt_s);
        end
    end

    assign therm_since = fire ? 9'd0 :
                         (cur.since_ms != SINCE_MAX) ? cur.since_ms + 9'd1 : cur.since_ms;

    // preheat end test uses the target before this tick's trim
    assign pre_done = p_s > tgt_s;

    assign trim_s = $signed({2'b0, cur.target}) + $signed({{4{item.enc_delta[4]}}, item.enc_delta});
    always_comb begin
        if (trim_s < $signed({2'b0, TARGET_MIN})) begin
            trim = TARGET_MIN;
        end else if (trim_s > $signed({2'b0, TARGET_MAX})) begin
            trim = TARGET_MAX;
        end else begin
            trim = trim_s[6:0];
        end
    end

    assign min_c     = ({1'b0, minutes} > 9'(MAX_WASH_MINUTES)) ? 9'(MAX_WASH_MINUTES)
                                                               : {1'b0, minutes};
    assign start_sec = 15'(min_c) * SEC_PER_MIN;

    // one millisecond off, saturating at zero
    always_comb begin
        if (cur.wash_ms != 10'd0) begin
            dec_sec = cur.wash_sec;
            dec_ms  = cur.wash_ms - 10'd1;
        end else if (cur.wash_sec != 15'd0) begin
            dec_sec = cur.wash_sec - 15'd1;
            dec_ms  = MS_LAST;
        end else begin
            dec_sec = 15'd0;
            dec_ms  = 10'd0;
        end
    end

    // encoder adds 5 s per step, clamped to 0 .. 2^24-1 ms
    assign add_s = $signed({2'b0, dec_sec})
                 + $signed({{12{item.enc_delta[4]}}, item.enc_delta}) * $signed(SEC_PER_STEP);
    always_comb begin
        if (add_s < 17'sd0) begin
            add_sec = 15'd0;
            add_ms  = 10'd0;
        end else if (add_s > $signed({2'b0, WASH_SEC_MAX})
                     || (add_s == $signed({2'b0, WASH_SEC_MAX}) && dec_ms > WASH_MS_MAX)) begin
            add_sec = WASH_SEC_MAX;
            add_ms  = WASH_MS_MAX;
        end else begin
            add_sec = add_s[14:0];
            add_ms  = dec_ms;
        end
    end

    always_comb begin
        nxt       = cur;
        ev        = EV_NONE;
        wash_done = 1'b0;
        if (item.op == OP_TICK) begin
            unique case (cur.phase)
                PH_PREHEAT: begin
                    nxt.heater_lvl = therm_lvl;
                    nxt.since_ms   = therm_since;
                    if (item.enc_delta != 5'sd0) begin
                        nxt.target = trim;
                    end
                    if (pre_done) begin
                        nxt.pump       = PUMP_OFF;
                        nxt.heater_en  = 1'b0;
                        nxt.heater_lvl = 1'b0;
                        nxt.phase      = PH_IDLE;
                        if (cur.chain) begin
                            nxt.pump      = PUMP_FULL;
                            nxt.heater_en = 1'b1;
                            nxt.wash_sec  = start_sec;
                            nxt.wash_ms   = 10'd0;
                            nxt.phase     = PH_WASH;
                        end else begin
                            ev = EV_PREHEAT;
                        end
                    end
                end
                PH_WASH: begin
                    nxt.wash_sec = dec_sec;
                    nxt.wash_ms  = dec_ms;
                    if (dec_sec == 15'd0) begin
                        wash_done = 1'b1;
                    end else begin
                        nxt.heater_lvl = therm_lvl;
                        nxt.since_ms   = therm_since;
                        if (item.long_click) begin
                            wash_done = 1'b1;
                        end else if (item.enc_delta != 5'sd0) begin
                            nxt.wash_sec = add_sec;
                            nxt.wash_ms  = add_ms;
                            wash_done    = (add_sec == 15'd0);
                        end
                    end
                    if (wash_done) begin
                        nxt.pump       = PUMP_OFF;
                        nxt.heater_en  = 1'b0;
                        nxt.heater_lvl = 1'b0;
                        nxt.phase      = PH_IDLE;
                        nxt.chain      = 1'b0;
                        ev             = cur.chain ? EV_CYCLE_DONE : EV_WASH;
                    end
                end
                default: begin
                    nxt.heater_lvl = therm_lvl;
                    nxt.since_ms   = therm_since;
                end
            endcase
        end else if (cur.phase == PH_IDLE) begin
            unique case (item.op)
                OP_PREHEAT, OP_PREHEAT_WASH: begin
                    nxt.chain     = (item.op == OP_PREHEAT_WASH);
                    nxt.pump      = PUMP_HALF;
                    nxt.heater_en = 1'b1;
                    nxt.phase     = PH_PREHEAT;
                end
                OP_WASH: begin
                    nxt.chain     = 1'b0;
                    nxt.pump      = PUMP_FULL;
                    nxt.heater_en = 1'b1;
                    nxt.wash_sec  = start_sec;
                    nxt.wash_ms   = 10'd0;
                    nxt.phase     = PH_WASH;
                end
                OP_HEAT_ON:   nxt.heater_en = 1'b1;
                OP_HEAT_OFF: begin
                    nxt.heater_en  = 1'b0;
                    nxt.heater_lvl = 1'b0;
                end
                OP_PUMP_OFF:  nxt.pump = PUMP_OFF;
                OP_PUMP_HALF: nxt.pump = PUMP_HALF;
                OP_PUMP_FULL: nxt.pump = PUMP_FULL;
                default: ;
            endcase
        end
    end

    always_comb begin
        res.heater_drive = nxt.heater_lvl;
        unique case (nxt.pump)
            PUMP_HALF: res.pump_duty = HALF_DUTY;
            PUMP_FULL: res.pump_duty = full_duty;
            default:   res.pump_duty = 8'd0;
        endcase
        res.phase             = nxt.phase;
        res.remaining_seconds = (nxt.phase == PH_WASH) ? nxt.wash_sec : 15'd0;
        res.working_target    = nxt.target;
        res.end_event         = ev;
    end

endmodule

// ----- src/preheat_wash_cycle_controller.sv -----
// Preheat/wash cycle controller.
// An input transfer goes through the input register, then the state update
// and result register, to m_axis. Throughput: one item per cycle unless m_axis
// backpressure stalls the output; the state loop is one pass of the step logic.
// Reset (aresetn low, synchronous): config registers and state return to their
// defaults, both pipeline stages empty.
`include "preheat_wash_cycle_controller_assert.svh"

module preheat_wash_cycle_controller
    import pwcc_pkg::*;
#(
    parameter int unsigned MAX_WASH_MINUTES = MAX_WASH_MINUTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // heater_temp[15:0], pipe_temp[31:16], enc_delta[36:32], long_click[37]
    input  logic [39:0] s_axis_tdata,
    // opcode[3:0]
    input  logic [3:0]  s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // heater_drive[0], pump_duty[8:1], phase[10:9], remaining_seconds[25:11],
    // working_target[32:26], end_event[34:33]
    output logic [39:0] m_axis_tdata
);

    logic [7:0] minutes_reg;
    logic [7:0] duty_reg;
    state_t     state_reg;
    state_t     state_next;
    logic       in_valid_reg;
    item_t      in_item_reg;
    logic       out_valid_reg;
    result_t    out_reg;
    result_t    res_next;
    logic       advance;
    logic       in_take;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    pwcc_step #(
        .MAX_WASH_MINUTES(MAX_WASH_MINUTES)
    ) u_step (
        .item      (in_item_reg),
        .cur       (state_reg),
        .minutes   (minutes_reg),
        .full_duty (duty_reg),
        .nxt       (state_next),
        .res       (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
        if (in_take) begin
            in_item_reg.op          <= s_axis_tuser;
            in_item_reg.heater_temp <= s_axis_tdata[15:0];
            in_item_reg.pipe_temp   <= s_axis_tdata[31:16];
            in_item_reg.enc_delta   <= s_axis_tdata[36:32];
            in_item_reg.long_click  <= s_axis_tdata[37];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_reg <= res_next;
        end
    end

    // state and config; config writes must arrive only while no item is in flight (the block does not enforce this)
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            minutes_reg          <= MINUTES_RESET;
            duty_reg             <= FULL_DUTY_RESET;
            state_reg.phase      <= PH_IDLE;
            state_reg.chain      <= 1'b0;
            state_reg.heater_en  <= 1'b0;
            state_reg.heater_lvl <= 1'b0;
            state_reg.pump       <= PUMP_OFF;
            state_reg.since_ms   <= SINCE_MAX;
            state_reg.target     <= TARGET_RESET;
            state_reg.wash_sec   <= 15'd0;
            state_reg.wash_ms    <= 10'd0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    CFG_TARGET: begin
                        state_reg.target <= cfg_wr_data[6:0];
                    end
                    CFG_MINUTES:   minutes_reg <= cfg_wr_data;
                    CFG_FULL_DUTY: duty_reg    <= cfg_wr_data;
                    default: ;
                endcase
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_reg.end_event, out_reg.working_target,
                            out_reg.remaining_seconds, out_reg.phase,
                            out_reg.pump_duty, out_reg.heater_drive};

    `PWCC_ASSERT_IMPL(a_lvl_needs_en, aclk, aresetn, state_reg.heater_lvl,
        state_reg.heater_en, "heater output high while heater disabled")
    `PWCC_ASSERT_IMPL(a_event_idle, aclk, aresetn, m_axis_tvalid && out_reg.end_event != EV_NONE,
        out_reg.phase == PH_IDLE, "end event outside idle phase")
    `PWCC_ASSERT_IMPL(a_secs_wash, aclk, aresetn,
        m_axis_tvalid && out_reg.remaining_seconds != 15'd0,
        out_reg.phase == PH_WASH, "remaining time shown outside wash")
    `PWCC_ASSERT_NEXT(a_adv_result, aclk, aresetn, advance, m_axis_tvalid,
        "advanced item did not reach the result register")

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps

import pwcc_pkg::*;

// Mirrors the controller state and keeps the outputs owed by the block, oldest first.
class wash_scoreboard;
    logic [6:0] reg_target;
    logic [7:0] reg_minutes;
    logic [7:0] reg_full_duty;
    phase_t     phase;
    bit         chain;
    bit         heat_en;
    bit         heat_lvl;
    pump_t      pump;
    int         since_ms;
    logic [6:0] target;
    int         wash_left;
    result_t    outputs_due[$];
    int         errors;

    function void clear();
        reg_target    = TARGET_RESET;
        reg_minutes   = MINUTES_RESET;
        reg_full_duty = FULL_DUTY_RESET;
        phase         = PH_IDLE;
        chain         = 1'b0;
        heat_en       = 1'b0;
        heat_lvl      = 1'b0;
        pump          = PUMP_OFF;
        since_ms      = SINCE_MAX;
        target        = TARGET_RESET;
        wash_left     = 0;
        errors        = 0;
        outputs_due.delete();
    endfunction

    function void set_reg(cfg_index_t idx, logic [7:0] value);
        case (idx)
            CFG_TARGET: begin
                reg_target = value[6:0];
                target     = value[6:0];
            end
            CFG_MINUTES: reg_minutes = value;
            default: reg_full_duty = value;
        endcase
    endfunction

    // hysteresis: off at target - 2 C, on at target - 1 C, checked only once since_ms exceeds CHECK_GAP_MS
    function void run_thermostat(int heater_temp);
        int setpoint;
        if (heat_en && since_ms > CHECK_GAP_MS) begin
            setpoint = int'(target) * 100;
            if (heat_lvl) begin
                if (heater_temp + 200 >= setpoint) heat_lvl = 1'b0;
            end else if (heater_temp + 100 <= setpoint) begin
                heat_lvl = 1'b1;
            end
            since_ms = 0;
        end else if (since_ms < SINCE_MAX) begin
            since_ms++;
        end
    endfunction

    function void shut_down();
        pump     = PUMP_OFF;
        heat_en  = 1'b0;
        heat_lvl = 1'b0;
    endfunction

    function void start_wash();
        int minutes;
        minutes = reg_minutes;
        if (minutes > MAX_WASH_MINUTES_DEF) minutes = MAX_WASH_MINUTES_DEF;
        pump      = PUMP_FULL;
        heat_en   = 1'b1;
        wash_left = minutes * 60000;
        phase     = PH_WASH;
    endfunction

    function void note_item(logic [3:0] op, logic signed [15:0] heater_temp,
                            logic signed [15:0] pipe_temp, logic signed [4:0] steps,
                            logic click);
        bit      done;
        int      trimmed;
        longint  rest;
        event_t  ev;
        result_t want;
        ev = EV_NONE;
        if (op == OP_TICK) begin
            case (phase)
                PH_PREHEAT: begin
                    // end test uses the target before this tick's trim
                    done = int'(pipe_temp) + 100 > int'(target) * 100;
                    run_thermostat(heater_temp);
                    if (steps != 0) begin
                        trimmed = int'(target) + int'(steps);
                        if (trimmed < int'(TARGET_MIN)) trimmed = TARGET_MIN;
                        if (trimmed > int'(TARGET_MAX)) trimmed = TARGET_MAX;
                        target = trimmed[6:0];
                    end
                    if (done) begin
                        shut_down();
                        phase = PH_IDLE;
                        if (chain) start_wash();
                        else ev = EV_PREHEAT;
                    end
                end
                PH_WASH: begin
                    done = 1'b0;
                    if (wash_left > 0) wash_left--;
                    if (wash_left < 1000) begin
                        done = 1'b1;
                    end else begin
                        run_thermostat(heater_temp);
                        if (click) begin
                            done = 1'b1;
                        end else if (steps != 0) begin
                            // 5 s per encoder step, held to the 24-bit counter
                            rest = longint'(wash_left) + longint'(steps) * 5000;
                            if (rest < 0) rest = 0;
                            if (rest > 64'hFF_FFFF) rest = 64'hFF_FFFF;
                            wash_left = int'(rest);
                            if (wash_left < 1000) done = 1'b1;
                        end
                    end
                    if (done) begin
                        shut_down();
                        phase = PH_IDLE;
                        ev    = chain ? EV_CYCLE_DONE : EV_WASH;
                        chain = 1'b0;
                    end
                end
                default: run_thermostat(heater_temp);
            endcase
        end else if (phase == PH_IDLE && op <= OP_PUMP_FULL) begin
            case (op)
                OP_PREHEAT, OP_PREHEAT_WASH: begin
                    chain   = (op == OP_PREHEAT_WASH);
                    pump    = PUMP_HALF;
                    heat_en = 1'b1;
                    phase   = PH_PREHEAT;
                end
                OP_WASH: begin
                    chain = 1'b0;
                    start_wash();
                end
                OP_HEAT_ON: heat_en = 1'b1;
                OP_HEAT_OFF: begin
                    heat_en  = 1'b0;
                    heat_lvl = 1'b0;
                end
                OP_PUMP_OFF: pump = PUMP_OFF;
                OP_PUMP_HALF: pump = PUMP_HALF;
                default: pump = PUMP_FULL;
            endcase
        end
        want.heater_drive      = heat_lvl;
        want.pump_duty         = (pump == PUMP_HALF) ? HALF_DUTY :
                                 (pump == PUMP_FULL) ? reg_full_duty : 8'd0;
        want.phase             = phase;
        want.remaining_seconds = (phase == PH_WASH) ? 15'(wash_left / 1000) : 15'd0;
        want.working_target    = target;
        want.end_event         = ev;
        outputs_due.push_back(want);
    endfunction

    function void compare_field(string name, int exp_val, int got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            errors++;
        end
    endfunction

    function void check_output(logic [39:0] data);
        result_t want;
        if (outputs_due.size() == 0) begin
            $error("output transfer with nothing outstanding: %h", data);
            errors++;
            return;
        end
        want = outputs_due.pop_front();
        compare_field("heater_drive", want.heater_drive, data[0]);
        compare_field("pump_duty", want.pump_duty, data[8:1]);
        compare_field("phase", want.phase, data[10:9]);
        compare_field("remaining_seconds", want.remaining_seconds, data[25:11]);
        compare_field("working_target", want.working_target, data[32:26]);
        compare_field("end_event", want.end_event, data[34:33]);
    endfunction
endclass

module tb;

    typedef enum {RX_OPEN, RX_COIN, RX_PERIODIC, RX_STARVED} rx_pattern_t;

    localparam logic signed [4:0] STEP_MIN = -16;
    localparam logic signed [4:0] STEP_MAX = 15;

    logic        aclk          = 1'b0;
    logic        aresetn       = 1'b0;
    logic        cfg_wr_en     = 1'b0;
    logic [1:0]  cfg_addr      = CFG_TARGET;
    logic [7:0]  cfg_wr_data   = 8'd0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = 40'd0;
    logic [3:0]  s_axis_tuser  = OP_TICK;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [39:0] m_axis_tdata;

    wash_scoreboard wash_sb;
    int          useful_items = 0;
    int          burst_left   = 0;
    rx_pattern_t rx_pattern   = RX_OPEN;
    int          rx_span      = 0;

    preheat_wash_cycle_controller u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wr_data   (cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // receiver backpressure, switching pattern every so often
    always @(posedge aclk) begin
        if (rx_span == 0) begin
            rx_pattern = rx_pattern_t'($urandom_range(0, 3));
            rx_span    = $urandom_range(16, 160);
        end
        rx_span--;
        case (rx_pattern)
            RX_OPEN: m_axis_tready <= 1'b1;
            RX_COIN: m_axis_tready <= $urandom_range(0, 1);
            RX_PERIODIC: m_axis_tready <= (rx_span % 4 != 0);
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge aclk) begin
        if (aresetn && m_axis_tvalid && m_axis_tready) wash_sb.check_output(m_axis_tdata);
    end

    function automatic logic signed [15:0] rand_temp();
        if ($urandom_range(0, 7) == 0) return 16'($urandom);
        return 16'(int'($urandom_range(0, 35000)) - 5000);
    endfunction

    // heater reading around the working target so the thermostat toggles
    function automatic logic signed [15:0] temp_near();
        if ($urandom_range(0, 7) == 0) return rand_temp();
        return 16'(int'(wash_sb.target) * 100 + int'($urandom_range(0, 800)) - 400);
    endfunction

    function automatic logic signed [15:0] pipe_cold();
        if ($urandom_range(0, 15) == 0) return 16'sh8000;
        return 16'(int'(wash_sb.target) * 100 - 100 - int'($urandom_range(0, 3000)));
    endfunction

    function automatic logic signed [15:0] pipe_warm();
        if ($urandom_range(0, 15) == 0) return 16'sh7FFF;
        return 16'(int'(wash_sb.target) * 100 - 99 + int'($urandom_range(0, 2000)));
    endfunction

    function automatic logic signed [4:0] trim_steps();
        if ($urandom_range(0, 3) == 0) return 5'($urandom);
        return 5'sd0;
    endfunction

    function automatic logic signed [4:0] wash_steps();
        case ($urandom_range(0, 7))
            0: return 5'($urandom_range(1, 15));
            1: return 5'(-int'($urandom_range(1, 3)));
            default: return 5'sd0;
        endcase
    endfunction

    task automatic push_item(input logic [3:0] op, input logic signed [15:0] heater_temp,
                             input logic signed [15:0] pipe_temp,
                             input logic signed [4:0] steps, input logic click);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 6);
            repeat (gap) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {2'b00, click, steps, pipe_temp, heater_temp};
        do @(posedge aclk); while (!s_axis_tready);
        // commands while busy and unknown opcodes are dropped by the block
        if (op <= OP_PUMP_FULL && (op == OP_TICK || wash_sb.phase == PH_IDLE))
            useful_items++;
        wash_sb.note_item(op, heater_temp, pipe_temp, steps, click);
        burst_left--;
        if (burst_left == 0) s_axis_tvalid <= 1'b0;
    endtask

    task automatic busy_noise();
        push_item(4'($urandom_range(1, 15)), rand_temp(), rand_temp(), 5'($urandom),
                  1'($urandom));
    endtask

    // hold the sender until every owed output has arrived
    task automatic wait_quiet();
        if (burst_left != 0) begin
            s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
        while (wash_sb.outputs_due.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_settings(input logic [6:0] tgt, input logic [7:0] minutes,
                                  input logic [7:0] duty);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_TARGET;
        cfg_wr_data <= {1'b0, tgt};
        @(posedge aclk);
        wash_sb.set_reg(CFG_TARGET, {1'b0, tgt});
        cfg_addr    <= CFG_MINUTES;
        cfg_wr_data <= minutes;
        @(posedge aclk);
        wash_sb.set_reg(CFG_MINUTES, minutes);
        cfg_addr    <= CFG_FULL_DUTY;
        cfg_wr_data <= duty;
        @(posedge aclk);
        wash_sb.set_reg(CFG_FULL_DUTY, duty);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic wash_body();
        int n;
        int i;
        int ending;
        n = $urandom_range(1, 30);
        for (i = 0; i < n && wash_sb.phase == PH_WASH; i++) begin
            if ($urandom_range(0, 9) == 0) busy_noise();
            else push_item(OP_TICK, temp_near(), rand_temp(), wash_steps(), 1'b0);
        end
        ending = $urandom_range(0, 3);
        if (ending == 0) begin
            // push time up toward the counter ceiling before aborting
            n = $urandom_range(5, 40);
            for (i = 0; i < n && wash_sb.phase == PH_WASH; i++)
                push_item(OP_TICK, temp_near(), rand_temp(), STEP_MAX, 1'b0);
        end
        while (wash_sb.phase == PH_WASH) begin
            if (ending == 1) push_item(OP_TICK, temp_near(), rand_temp(), STEP_MIN, 1'b0);
            else push_item(OP_TICK, temp_near(), rand_temp(), 5'($urandom), 1'b1);
        end
    endtask

    task automatic preheat_run(input bit chained);
        int n;
        int i;
        push_item(chained ? OP_PREHEAT_WASH : OP_PREHEAT, rand_temp(), rand_temp(),
                  5'($urandom), 1'($urandom));
        n = $urandom_range(1, 40);
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 9) == 0) busy_noise();
            else push_item(OP_TICK, temp_near(), pipe_cold(), trim_steps(), 1'($urandom));
        end
        push_item(OP_TICK, temp_near(), pipe_warm(), trim_steps(), 1'($urandom));
        if (chained) wash_body();
    endtask

    task automatic idle_noise();
        int n;
        int i;
        n = $urandom_range(1, 10);
        for (i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0: push_item(4'($urandom_range(9, 15)), rand_temp(), rand_temp(),
                             5'($urandom), 1'($urandom));
                1: push_item(OP_TICK, temp_near(), rand_temp(), 5'($urandom), 1'($urandom));
                default: push_item(4'($urandom_range(OP_HEAT_ON, OP_PUMP_FULL)), rand_temp(),
                                   rand_temp(), 5'($urandom), 1'($urandom));
            endcase
        end
    endtask

    task automatic run_directed();
        push_item(OP_TICK, 16'sh8000, 16'sh7FFF, STEP_MIN, 1'b1);
        push_item(OP_TICK, 16'sh7FFF, 16'sh8000, STEP_MAX, 1'b0);
        push_item(4'd15, 16'sh7FFF, 16'sh7FFF, 5'sd0, 1'b1);
        push_item(4'd9, 16'sd0, 16'sd0, 5'sd0, 1'b0);
        push_item(OP_HEAT_ON, 16'sd0, 16'sd0, 5'sd0, 1'b0);
        push_item(OP_TICK, 16'sd3700, 16'sd0, 5'sd0, 1'b0);
        push_item(OP_PUMP_HALF, 16'sd0, 16'sd0, 5'sd0, 1'b0);
        push_item(OP_PUMP_FULL, 16'sd0, 16'sd0, 5'sd0, 1'b0);
        push_item(OP_PUMP_OFF, 16'sd0, 16'sd0, 5'sd0, 1'b0);
        push_item(OP_HEAT_OFF, 16'sd0, 16'sd0, 5'sd0, 1'b0);
        // trim clamps at both ends of the target window
        push_item(OP_PREHEAT, 16'sd0, 16'sd0, 5'sd0, 1'b0);
        push_item(OP_TICK, 16'sd3900, 16'sd3000, STEP_MAX, 1'b0);
        push_item(OP_TICK, 16'sd4300, 16'sd4300, STEP_MIN, 1'b0);
        push_item(OP_TICK, 16'sd2500, 16'sd2700, STEP_MIN, 1'b0);
        push_item(OP_WASH, 16'sd0, 16'sd0, 5'sd0, 1'b0);
        push_item(OP_TICK, 16'sd1500, 16'sd2000, 5'sd0, 1'b0);
        push_item(OP_WASH, 16'sd0, 16'sd0, 5'sd0, 1'b0);
        push_item(OP_TICK, 16'sd1900, 16'sd0, STEP_MAX, 1'b0);
        push_item(OP_TICK, 16'sd1900, 16'sd0, 5'sd0, 1'b1);
        push_item(OP_PREHEAT_WASH, 16'sd0, 16'sd0, 5'sd0, 1'b0);
        push_item(OP_TICK, 16'sd1800, 16'sd30000, 5'sd0, 1'b0);
        push_item(OP_PREHEAT, 16'sd0, 16'sd0, 5'sd0, 1'b0);
        push_item(OP_TICK, 16'sd1800, 16'sd0, STEP_MIN, 1'b0);
        push_item(OP_TICK, 16'sd1800, 16'sd0, 5'sd0, 1'b1);
    endtask

    // zero-minute wash: nothing left, so the first tick runs it out on its own
    task automatic run_timed_wash();
        push_item(OP_WASH, 16'sd4000, 16'sd2500, 5'sd0, 1'b0);
        while (wash_sb.phase == PH_WASH)
            push_item(OP_TICK, temp_near(), rand_temp(), 5'sd0, 1'b0);
    endtask

    task automatic pick_scenario();
        case ($urandom_range(0, 9))
            0, 1, 2: preheat_run(1'b0);
            3, 4: preheat_run(1'b1);
            5, 6, 7: begin
                push_item(OP_WASH, rand_temp(), rand_temp(), 5'($urandom), 1'($urandom));
                wash_body();
            end
            default: idle_noise();
        endcase
    endtask

    initial begin
        int k;
        wash_sb = new;
        wash_sb.clear();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        run_directed();
        wait_quiet();
        write_settings(7'd40, 8'd0, 8'd200);
        run_timed_wash();
        for (k = 0; k < 5; k++) begin
            wait_quiet();
            case (k)
                0: write_settings(TARGET_MIN, 8'd1, 8'd100);
                1: write_settings(7'd65, 8'd255, 8'd255);
                2: write_settings(TARGET_MAX, 8'($urandom_range(1, 240)),
                                  8'($urandom_range(100, 255)));
                default: write_settings(7'($urandom_range(20, 65)), 8'($urandom_range(1, 240)),
                                        8'($urandom_range(100, 255)));
            endcase
            useful_items = 0;
            while (useful_items < 190) pick_scenario();
        end
        wait_quiet();
        repeat (10) @(posedge aclk);
        if (wash_sb.errors == 0 && wash_sb.outputs_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- preheat_wash_cycle_controller.f -----
+incdir+src
src/pwcc_pkg.sv
src/pwcc_step.sv
src/preheat_wash_cycle_controller.sv
sim/tb.sv
